// ===== sv/bhn_pkg.sv =====
package bhn_pkg;

  localparam int MAX_BINS = 16;
  localparam int IDX_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W    = $clog2(MAX_BINS + 1);

  localparam int FIELD_W = 31;
  localparam int BIN_W   = 32;
  localparam int ABS_W   = 40;
  localparam int SQ_W    = 64;
  localparam int EPS_W   = 16;
  localparam int VAL_W   = 16;
  localparam int DIV_W   = 40;
  localparam int QUO_W   = 32;
  localparam int ROOT_W  = 32;
  localparam int SQ2_W   = 40;
  localparam int STEP_W  = 6;

  localparam logic [VAL_W-1:0] CLIP_Q16 = 16'd13107;
  localparam logic [VAL_W-1:0] VAL_MAX  = 16'hFFFF;

  // register indexes on the config port
  localparam logic [1:0] REG_NORM_MODE = 2'd0;
  localparam logic [1:0] REG_EPSILON   = 2'd1;

  typedef enum logic [1:0] {
    MODE_L1      = 2'd0,
    MODE_L1_SQRT = 2'd1,
    MODE_L2      = 2'd2,
    MODE_L2_HYS  = 2'd3
  } norm_mode_t;

  typedef struct packed {
    logic [FIELD_W-1:0] corner_top_left;
    logic [FIELD_W-1:0] corner_top_right;
    logic [FIELD_W-1:0] corner_bottom_left;
    logic [FIELD_W-1:0] corner_bottom_right;
    logic               last_bin;
  } bin_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] bin_value;
    logic             block_last;
  } res_word_t;

  typedef struct packed {
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic             zero;
    logic             cap;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

// ===== sv/bhn_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module bhn_div
  import bhn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  div_cmd_t cmd,
  output div_res_t res
);

  logic              busy;
  logic              done_r;
  logic              zero_r;
  logic              cap_r;
  logic [STEP_W-1:0] left;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  den;
  logic [QUO_W-1:0]  quo;
  logic [DIV_W:0]    rem2;

  assign rem2 = {rem, 1'b0};
  assign res  = {done_r, zero_r, cap_r, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        zero_r <= 1'b0;
        cap_r  <= 1'b0;
        quo    <= '0;
        if (cmd.den == '0) begin
          zero_r <= 1'b1;
          done_r <= 1'b1;
        end else if (cmd.num >= cmd.den) begin
          cap_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          busy <= 1'b1;
          left <= cmd.steps;
          rem  <= cmd.num;
          den  <= cmd.den;
        end
      end else if (busy) begin
        if (rem2 >= {1'b0, den}) begin
          rem <= DIV_W'(rem2 - {1'b0, den});
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= rem2[DIV_W-1:0];
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        left <= left - STEP_W'(1);
        if (left == STEP_W'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/bhn_isqrt.sv =====
// digit-by-digit square root, two radicand bits per cycle
module bhn_isqrt
  import bhn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 4;

  logic              busy;
  logic [STEP_W-1:0] left;
  logic [SQ_W-1:0]   xs;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_in;
  logic [REM_W-1:0]  trial;

  assign rem_in = {rem[REM_W-3:0], xs[SQ_W-1:SQ_W-2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= STEP_W'(ROOT_W);
        xs   <= x;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        xs <= {xs[SQ_W-3:0], 2'b00};
        if (rem_in >= trial) begin
          rem  <= rem_in - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_in;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        left <= left - STEP_W'(1);
        if (left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/block_histogram_normalizer_top.sv =====
// channel | direction | handshake             | word
// bin     | in        | bin_valid / bin_stall | bin_word_t: four corners, last_bin
// res     | out       | res_valid / res_stall | res_word_t: bin_value, block_last
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a bin word: bin sum, abs total and square product are registered first, then the square add
// the block end runs a bit-serial divider and a root unit
// bins stall while the block end runs
// synchronous reset, no clearing pass; results wait in an output register
module block_histogram_normalizer_top
  import bhn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             bin_valid,
  output logic             bin_stall,
  input  bin_word_t        bin_word,
  output logic             res_valid,
  input  logic             res_stall,
  output res_word_t        res_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [EPS_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_NSQ_GO, S_NSQ_WAIT, S_READ, S_DIV_GO, S_DIV_WAIT,
    S_F_GO, S_F_WAIT, S_HYS_MUL, S_HYS_ACC, S_N2_GO, S_N2_WAIT, S_EMIT
  } state_t;

  state_t            state;
  norm_mode_t        norm_mode;
  logic [EPS_W-1:0]  epsilon;
  logic [CNT_W-1:0]  bin_count;
  logic [ABS_W-1:0]  abs_total;
  logic [SQ_W-1:0]   square_total;
  logic [SQ_W-1:0]   sq_prod;
  logic              last_r;
  logic              pass_clip;
  logic [IDX_W-1:0]  idx;
  logic [ROOT_W-1:0] nroot;
  logic [ROOT_W-1:0] n2;
  logic [SQ2_W-1:0]  sq2;
  logic [VAL_W-1:0]  creg;
  logic [2*VAL_W-1:0] csq;
  logic [VAL_W-1:0]  vreg;

  // bin store
  logic [BIN_W-1:0]  bin_store [MAX_BINS];
  logic [BIN_W-1:0]  rd_data;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [BIN_W-1:0]  mem_wd;

  // datapath wires
  logic              accept;
  logic              full;
  logic              slot_free;
  logic              last_idx;
  logic [BIN_W-1:0]  pos;
  logic [BIN_W-1:0]  neg;
  logic [BIN_W-1:0]  s;
  logic [ABS_W:0]    abs_sum;
  logic [SQ_W:0]     sq_sum;
  logic              eps_wr;
  logic              mode_wr;
  logic [EPS_W-1:0]  seed_src;
  logic [23:0]       seed_e;
  logic [47:0]       seed_ee;
  logic [ABS_W-1:0]  seed_abs;
  logic [SQ_W-1:0]   seed_sq;
  logic [VAL_W-1:0]  v2;
  logic [VAL_W-1:0]  cval;
  logic              hys_write;

  // serial units
  logic              dv_start;
  div_cmd_t          dv_cmd;
  div_res_t          dv_res;
  logic              sr_start;
  logic [SQ_W-1:0]   sr_x;
  logic              sr_done;
  logic [ROOT_W-1:0] sr_root;

  assign cfg_ready = 1'b1;
  assign bin_stall = (state != S_IDLE);
  assign accept    = bin_valid && !bin_stall;
  assign full      = (bin_count == CNT_W'(MAX_BINS));
  assign slot_free = !res_valid || !res_stall;
  assign last_idx  = ((CNT_W'(idx) + CNT_W'(1)) == bin_count);
  assign eps_wr    = cfg_valid && cfg_ready && (cfg_index == REG_EPSILON);
  assign mode_wr   = cfg_valid && cfg_ready && (cfg_index == REG_NORM_MODE);

  // bin sum, clamped at zero
  assign pos = BIN_W'(bin_word.corner_top_left) + BIN_W'(bin_word.corner_bottom_right);
  assign neg = BIN_W'(bin_word.corner_top_right) + BIN_W'(bin_word.corner_bottom_left);
  assign s   = (pos > neg) ? (pos - neg) : '0;

  // saturating totals
  assign abs_sum = {1'b0, abs_total} + (ABS_W + 1)'({s, 4'b0000});
  assign sq_sum  = {1'b0, square_total} + {1'b0, sq_prod};

  // epsilon seed: e = 255 * eps, abs = e / 4096, square = e^2 / 2^32
  always_comb begin
    seed_src = eps_wr ? cfg_data : epsilon;
    seed_e   = {8'b0, seed_src} * 24'd255;
    seed_ee  = {24'b0, seed_e} * {24'b0, seed_e};
    seed_abs = ABS_W'(seed_e >> 12);
    seed_sq  = SQ_W'(seed_ee >> 32);
  end

  // divider result as a q0.16 value, then the hys clip
  assign v2        = dv_res.zero ? '0 : (dv_res.cap ? VAL_MAX : dv_res.quo[VAL_W-1:0]);
  assign cval      = (v2 > CLIP_Q16) ? CLIP_Q16 : v2;
  assign hys_write = (state == S_DIV_WAIT) && dv_res.done && pass_clip;

  // store write: raw sums on accept, clipped values on the hys first pass
  assign mem_we = (accept && !full) || hys_write;
  assign mem_wa = accept ? bin_count[IDX_W-1:0] : idx;
  assign mem_wd = accept ? s : BIN_W'(cval);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_store[mem_wa] <= mem_wd;
    end
    rd_data <= bin_store[idx];
  end

  // divider operands
  always_comb begin
    dv_start = (state == S_DIV_GO);
    case (norm_mode)
      MODE_L1, MODE_L1_SQRT: begin
        dv_cmd.num   = DIV_W'({rd_data, 4'b0000});
        dv_cmd.den   = abs_total;
        dv_cmd.steps = STEP_W'(QUO_W);
      end
      default: begin
        dv_cmd.num   = DIV_W'(rd_data);
        dv_cmd.den   = (norm_mode == MODE_L2_HYS && !pass_clip) ? DIV_W'(n2) : DIV_W'(nroot);
        dv_cmd.steps = STEP_W'(VAL_W);
      end
    endcase
  end

  // root operand
  always_comb begin
    sr_start = (state == S_NSQ_GO) || (state == S_F_GO) || (state == S_N2_GO);
    case (state)
      S_NSQ_GO: sr_x = square_total;
      S_N2_GO:  sr_x = SQ_W'(sq2);
      default:  sr_x = SQ_W'(dv_res.quo);
    endcase
  end

  bhn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .cmd   (dv_cmd),
    .res   (dv_res)
  );

  bhn_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sr_start),
    .x     (sr_x),
    .done  (sr_done),
    .root  (sr_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      norm_mode    <= MODE_L2_HYS;
      epsilon      <= EPS_W'(1);
      bin_count    <= '0;
      abs_total    <= '0;
      square_total <= '0;
      res_valid    <= 1'b0;
      idx          <= '0;
      pass_clip    <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      // the user must send config writes only while idle; the block itself does not enforce it
      if (mode_wr) begin
        norm_mode <= norm_mode_t'(cfg_data[1:0]);
      end
      if (eps_wr) begin
        epsilon <= cfg_data;
        if (bin_count == '0) begin
          abs_total    <= seed_abs;
          square_total <= seed_sq;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_r <= bin_word.last_bin;
            if (!full) begin
              bin_count <= bin_count + CNT_W'(1);
              abs_total <= abs_sum[ABS_W] ? '1 : abs_sum[ABS_W-1:0];
              sq_prod   <= {32'b0, s} * {32'b0, s};
            end else begin
              sq_prod <= '0;
            end
            state <= S_ACC;
          end
        end
        S_ACC: begin
          square_total <= sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
          if (last_r) begin
            idx       <= '0;
            sq2       <= SQ2_W'({16'b0, epsilon} * {16'b0, epsilon});
            pass_clip <= 1'b0;
            if (norm_mode == MODE_L2 || norm_mode == MODE_L2_HYS) begin
              state <= S_NSQ_GO;
            end else begin
              state <= S_READ;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_NSQ_GO: state <= S_NSQ_WAIT;
        S_NSQ_WAIT: begin
          if (sr_done) begin
            nroot     <= sr_root;
            pass_clip <= (norm_mode == MODE_L2_HYS);
            state     <= S_READ;
          end
        end
        S_READ:   state <= S_DIV_GO;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (dv_res.done) begin
            case (norm_mode)
              MODE_L1: begin
                vreg  <= dv_res.zero ? '0 :
                         (dv_res.cap ? VAL_MAX : dv_res.quo[QUO_W-1:QUO_W-VAL_W]);
                state <= S_EMIT;
              end
              MODE_L1_SQRT: begin
                if (dv_res.zero || dv_res.cap) begin
                  // a full fraction has root one, which saturates
                  vreg  <= dv_res.zero ? '0 : VAL_MAX;
                  state <= S_EMIT;
                end else begin
                  state <= S_F_GO;
                end
              end
              default: begin
                if (pass_clip) begin
                  creg  <= cval;
                  state <= S_HYS_MUL;
                end else begin
                  vreg  <= v2;
                  state <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_F_GO: state <= S_F_WAIT;
        S_F_WAIT: begin
          if (sr_done) begin
            vreg  <= sr_root[VAL_W-1:0];
            state <= S_EMIT;
          end
        end
        S_HYS_MUL: begin
          csq   <= creg * creg;
          state <= S_HYS_ACC;
        end
        S_HYS_ACC: begin
          sq2 <= sq2 + SQ2_W'(csq);
          if (last_idx) begin
            state <= S_N2_GO;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_READ;
          end
        end
        S_N2_GO: state <= S_N2_WAIT;
        S_N2_WAIT: begin
          if (sr_done) begin
            n2        <= sr_root;
            idx       <= '0;
            pass_clip <= 1'b0;
            state     <= S_READ;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            res_valid           <= 1'b1;
            res_word.bin_value  <= vreg;
            res_word.block_last <= last_idx;
            if (last_idx) begin
              // block closes: reseed the totals from the current epsilon
              bin_count    <= '0;
              abs_total    <= seed_abs;
              square_total <= seed_sq;
              state        <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bin_count <= CNT_W'(MAX_BINS))
    else $error("bin count beyond store depth");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> bin_stall)
    else $error("second bin word taken before accumulation");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && slot_free && last_idx) |=> (bin_count == '0))
    else $error("block end left bins counted");

  a_emit_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (bin_count != '0))
    else $error("emit with empty store");

endmodule

// ===== sim/bhn_checker.sv =====
module bhn_checker
  import bhn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             bin_valid,
  input  logic             bin_stall,
  input  bin_word_t        bin_word,
  input  logic             res_valid,
  input  logic             res_stall,
  input  res_word_t        res_word,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [EPS_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending_count
);

  logic [31:0]      raw_bins [MAX_BINS];
  logic [39:0]      l1_sum;
  logic [63:0]      l2_sum;
  int               stored;
  int               errs;
  norm_mode_t       mode;
  logic [EPS_W-1:0] eps;
  res_word_t        expected_q[$];

  assign pending_count = expected_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp16(logic [63:0] v);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic reseed();
    logic [63:0] e;
    e = 64'(eps) * 64'd255;
    l1_sum = 40'(e >> 12);
    l2_sum = (e * e) >> 32;
  endtask

  // fraction of the l1 total, 32 fractional bits, capped at one
  function automatic logic [63:0] frac32(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = 0;
    r = n;
    if (n >= d) return 64'd1 << 32;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic absorb_bin(bin_word_t w);
    logic [63:0] pos, neg, s, sq, acc;
    logic [15:0] vals [MAX_BINS];
    logic [63:0] n, n2, f, v;
    res_word_t   r;
    pos = 64'(w.corner_top_left) + 64'(w.corner_bottom_right);
    neg = 64'(w.corner_top_right) + 64'(w.corner_bottom_left);
    s = (pos > neg) ? pos - neg : 64'd0;
    if (stored < MAX_BINS) begin
      sq = s * s;
      raw_bins[stored] = s[31:0];
      stored++;
      acc = 64'(l1_sum) + (s << 4);
      l1_sum = (acc > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : acc[39:0];
      l2_sum = (l2_sum > ~sq) ? '1 : l2_sum + sq;
    end
    if (!w.last_bin) return;
    if (mode == MODE_L1 || mode == MODE_L1_SQRT) begin
      for (int i = 0; i < stored; i++) begin
        v = 0;
        if (l1_sum != 0) begin
          f = frac32(64'(raw_bins[i]) << 4, 64'(l1_sum));
          v = (mode == MODE_L1) ? (f >> 16) : int_sqrt(f);
        end
        vals[i] = clamp16(v);
      end
    end else begin
      n = int_sqrt(l2_sum);
      for (int i = 0; i < stored; i++)
        vals[i] = (n != 0) ? clamp16((64'(raw_bins[i]) << 16) / n) : 16'd0;
      if (mode == MODE_L2_HYS) begin
        // clip then renormalize with the live epsilon
        acc = 64'(eps) * 64'(eps);
        for (int i = 0; i < stored; i++) begin
          if (vals[i] > CLIP_Q16) vals[i] = CLIP_Q16;
          acc += 64'(vals[i]) * 64'(vals[i]);
        end
        n2 = int_sqrt(acc);
        for (int i = 0; i < stored; i++)
          vals[i] = (n2 != 0) ? clamp16((64'(vals[i]) << 16) / n2) : 16'd0;
      end
    end
    for (int i = 0; i < stored; i++) begin
      r.bin_value = vals[i];
      r.block_last = (i == stored - 1);
      expected_q.push_back(r);
    end
    stored = 0;
    reseed();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode <= MODE_L2_HYS;
      eps = 16'd1;
      stored = 0;
      reseed();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      errs = 0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NORM_MODE) begin
          mode <= norm_mode_t'(cfg_data[1:0]);
        end else if (cfg_index == REG_EPSILON) begin
          eps = cfg_data;
          if (stored == 0) reseed();
        end
      end
      if (bin_valid && !bin_stall) absorb_bin(bin_word);
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word bin_value=%0d", res_word.bin_value);
          errs++;
        end else begin
          res_word_t e;
          e = expected_q.pop_front();
          if (e.bin_value !== res_word.bin_value) begin
            $error("bin_value expected %0d actual %0d", e.bin_value, res_word.bin_value);
            errs++;
          end
          if (e.block_last !== res_word.block_last) begin
            $error("block_last expected %0b actual %0b", e.block_last, res_word.block_last);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== sim/tb_block_histogram_normalizer_top.sv =====
module tb_block_histogram_normalizer_top;
  import bhn_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic             clk;
  logic             rst;
  logic             bin_valid;
  logic             bin_stall;
  bin_word_t        bin_word;
  logic             res_valid;
  logic             res_stall;
  res_word_t        res_word;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [EPS_W-1:0] cfg_data;
  int               fail_count;
  int               pending_count;
  int               idle_cycles;

  block_histogram_normalizer_top dut (.*);
  bhn_checker chk (.*);

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // result side: random stall after each accepted word, some runs with none
  int res_gap;
  bit res_burst;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      res_gap = 0;
      res_burst = 0;
    end else if (res_gap > 0) begin
      res_gap--;
      res_stall <= (res_gap > 0);
    end else if (res_valid && !res_stall) begin
      if ($urandom_range(0, 31) == 0) res_burst = !res_burst;
      res_gap = res_burst ? 0 : $urandom_range(0, 11);
      res_stall <= (res_gap > 0);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (bin_valid && !bin_stall) || (res_valid && !res_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  bit no_gaps;

  // one bin word with a random wait in front of it; the block stalls the cycle
  // after an accepted word anyway, so the closing edge costs no throughput
  task automatic send_bin(bin_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    repeat (gap) @(posedge clk);
    bin_valid <= 1'b1;
    bin_word <= w;
    @(posedge clk);
    while (bin_stall) @(posedge clk);
    bin_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [EPS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [30:0] rand_corner(int kind);
    case (kind)
      0: return 31'h7FFF_FFFF;
      1: return 31'd0;
      2: return 31'($urandom_range(0, 1000));
      default: return 31'($urandom);
    endcase
  endfunction

  // random bin word whose sum is mostly small and positive
  function automatic bin_word_t rand_bin(bit last);
    bin_word_t w;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      w.corner_top_left = 31'($urandom) >> 1;
      w.corner_top_right = 31'($urandom) >> 2;
      w.corner_bottom_left = 31'($urandom) >> 2;
      w.corner_bottom_right = w.corner_top_right + w.corner_bottom_left
                              - w.corner_top_left + 31'($urandom_range(0, 4000));
      if (k == 0) w.corner_bottom_right = 31'($urandom);
    end else begin
      w.corner_top_left = rand_corner($urandom_range(0, 3));
      w.corner_top_right = rand_corner($urandom_range(0, 3));
      w.corner_bottom_left = rand_corner($urandom_range(0, 3));
      w.corner_bottom_right = rand_corner($urandom_range(0, 3));
    end
    w.last_bin = last;
    return w;
  endfunction

  function automatic bin_word_t make_bin(logic [30:0] tl, logic [30:0] tr,
                                         logic [30:0] bl, logic [30:0] br, bit last);
    bin_word_t w;
    w.corner_top_left = tl;
    w.corner_top_right = tr;
    w.corner_bottom_left = bl;
    w.corner_bottom_right = br;
    w.last_bin = last;
    return w;
  endfunction

  int sent;
  int blen;

  initial begin
    rst = 1'b1;
    bin_valid = 1'b0;
    bin_word = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_NORM_MODE;
    cfg_data = '0;
    no_gaps = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, extremes, clamp to zero, single-bin block
    send_bin(make_bin('1, 0, 0, '1, 0));
    send_bin(make_bin(0, '1, '1, 0, 0));
    send_bin(make_bin(5, 2, 1, 3, 0));
    send_bin(make_bin(31'h5555_5555, 31'h2AAA_AAAA, 0, 0, 1));
    send_bin(make_bin(0, 0, 0, 0, 1));
    drain();
    // zero epsilon in every mode: all-zero bins give a zero norm, then a single nonzero bin
    write_reg(REG_EPSILON, 16'd0);
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_NORM_MODE, 2'(m));
      send_bin(make_bin(0, 0, 0, 0, 0));
      send_bin(make_bin(0, 7, 0, 0, 1));
      send_bin(make_bin(0, 0, 0, 300, 1));
      drain();
    end
    // store full: 18 bins in one block, epsilon written mid-block
    write_reg(REG_EPSILON, 16'hFFFF);
    write_reg(REG_NORM_MODE, MODE_L2_HYS);
    for (int i = 0; i < 18; i++) begin
      send_bin(rand_bin(i == 17));
      if (i == 3) write_reg(REG_EPSILON, 16'd1234);
    end
    drain();

    // random blocks, settings changed between blocks
    sent = 0;
    while (sent < 320) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_reg(REG_NORM_MODE, 2'($urandom_range(0, 3)));
        case ($urandom_range(0, 3))
          0: write_reg(REG_EPSILON, 16'd0);
          1: write_reg(REG_EPSILON, 16'hFFFF);
          default: write_reg(REG_EPSILON, 16'($urandom));
        endcase
      end
      no_gaps = ($urandom_range(0, 5) == 0);
      blen = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
      for (int i = 0; i < blen; i++) send_bin(rand_bin(i == blen - 1));
      sent += blen;
      // sender waits for the whole block once in a while
      if ($urandom_range(0, 7) == 0)
        while (pending_count != 0) @(posedge clk);
    end

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bhn_pkg.sv
sv/bhn_div.sv
sv/bhn_isqrt.sv
sv/block_histogram_normalizer_top.sv
sim/bhn_checker.sv
sim/tb_block_histogram_normalizer_top.sv
